/* rtl/core/bfd_pkg.sv */
// Package for the binary fraction to decimal converter.
// Holds sizes, the queue word type and shared constants; depends on nothing.
package bfd_pkg;

  localparam int MAX_DIGITS   = 64;
  localparam int SRC_W        = 64;
  localparam int TOP_W        = 6;
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int COUNT_IN_W   = 7;
  localparam int DIGIT_W      = 4;
  localparam int LOWEST_SRC   = 12;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // One classified word: the fraction bits in consumption order (bit j is
  // folded in at step j) and the saturated digit count.
  typedef struct packed {
    logic [MAX_DIGITS-1:0] seq;
    logic [CNT_W-1:0]      count;
  } bfd_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } bfd_qstat_t;

endpackage

/* rtl/core/bfd_front.sv */
// Front end: accepts input words, saturates the digit count and assembles
// the fraction bit sequence. Depends on bfd_pkg.
module bfd_front import bfd_pkg::*; (
  input  logic [SRC_W-1:0]      source_bits_i,
  input  logic [TOP_W-1:0]      top_index_i,
  input  logic [COUNT_IN_W-1:0] digit_count_i,
  input  logic                  fill_bit_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bfd_qstat_t            qstat_i,
  output logic                  push_o,
  output bfd_item_t             item_o
);

  logic [SRC_W-1:0] rev;
  logic [SRC_W-1:0] shifted;
  logic [SRC_W-1:0] mask;
  logic [SRC_W-1:0] fill_word;
  logic [SRC_W-1:0] seq_full;
  logic [6:0]       src_len;

  always_comb begin
    for (int k = 0; k < SRC_W; k++) begin
      rev[k] = source_bits_i[SRC_W-1-k];
    end
    // Bit j of the sequence is source bit (top - j), which is rev[63 - top + j].
    shifted = rev >> (~top_index_i);
    if (top_index_i >= TOP_W'(LOWEST_SRC)) begin
      src_len = 7'(top_index_i) - 7'(LOWEST_SRC - 1);
    end else begin
      src_len = '0;
    end
    mask      = (SRC_W'(1) << src_len) - SRC_W'(1);
    fill_word = SRC_W'(fill_bit_i) << src_len;
    seq_full  = (shifted & mask) | fill_word;
  end

  always_comb begin
    item_o.seq = seq_full[MAX_DIGITS-1:0];
    if (digit_count_i > COUNT_IN_W'(MAX_DIGITS)) begin
      item_o.count = CNT_W'(MAX_DIGITS);
    end else begin
      item_o.count = CNT_W'(digit_count_i);
    end
  end

  // A word with no digits is accepted and dropped here.
  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full && (digit_count_i != '0);

endmodule

/* rtl/core/bfd_fifo.sv */
// Short queue between the front and back ends of the converter.
// Depends on bfd_pkg.
module bfd_fifo import bfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bfd_item_t  item_i,
  input  logic       pop_i,
  output bfd_item_t  item_o,
  output bfd_qstat_t qstat_o
);

  bfd_item_t         entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (fill_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (fill_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/bfd_back.sv */
// Back end: halves the decimal digit row once per fraction bit, then shifts
// the digits out through an output register. Depends on bfd_pkg.
module bfd_back import bfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfd_qstat_t         qstat_i,
  input  bfd_item_t          item_i,
  output logic               pop_o,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               last_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HALVE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      step_q, step_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [MAX_DIGITS-1:0] seq_q, seq_d;
  logic [DIGIT_W-1:0]    row_q [MAX_DIGITS];
  logic [DIGIT_W-1:0]    row_d [MAX_DIGITS];
  logic [DIGIT_W-1:0]    halved [MAX_DIGITS];
  logic                  ov_q, ov_d;
  logic [DIGIT_W-1:0]    digit_q, digit_d;
  logic                  last_q, last_d;
  logic                  slot_free;
  logic                  final_step;

  // The borrow into a digit is just the parity of the digit above it, so
  // every lane of one halving is independent.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (i == 0) begin
        halved[i] = (row_q[i] >> 1) + (seq_q[0] ? DIGIT_W'(5) : DIGIT_W'(0));
      end else begin
        halved[i] = (row_q[i] >> 1) + (row_q[i-1][0] ? DIGIT_W'(5) : DIGIT_W'(0));
      end
    end
  end

  assign slot_free  = !ov_q || out_ready_i;
  assign final_step = (step_q == count_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    seq_d   = seq_q;
    row_d   = row_q;
    ov_d    = ov_q && !out_ready_i;
    digit_d = digit_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          seq_d   = item_i.seq;
          count_d = item_i.count;
          step_d  = '0;
          for (int i = 0; i < MAX_DIGITS; i++) begin
            row_d[i] = '0;
          end
          state_d = ST_HALVE;
        end
      end
      ST_HALVE: begin
        row_d = halved;
        seq_d = seq_q >> 1;
        if (final_step) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          digit_d = row_q[0];
          last_d  = final_step;
          for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            row_d[i] = row_q[i+1];
          end
          row_d[MAX_DIGITS-1] = '0;
          step_d = step_q + CNT_W'(1);
          if (final_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    row_q   <= row_d;
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign out_valid_o = ov_q;
  assign digit_o     = digit_q;
  assign last_o      = last_q;

endmodule

/* rtl/core/binary_fraction_to_decimal.sv */
// Top level of the binary fraction to decimal converter.
// Instantiates bfd_front, bfd_fifo and bfd_back; depends on bfd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word: source bits,
//   top index, digit count and fill bit. The output channel
//   (out_valid_o / out_ready_i) returns digit_count decimal digits, most
//   significant first, with last_o set on the final one. Counts above 64
//   are treated as 64; a word with a zero count is taken and yields nothing.
//   A word passes the front end in its accept cycle into a two-entry queue.
//   The back end pops it from the queue when idle, halves its digit row
//   (one pass per fraction bit), then hands out one digit per cycle
//   through the output register while the receiver is ready. It takes
//   the next word only after the last digit of the current one, as the
//   halving passes and the digit emission share one row register.
//   The input stays ready while the queue has room, so up to two words
//   can wait while the back end works or the receiver stalls; a stalled
//   receiver holds the current digit and pauses emission.
//   Reset empties the queue and the output register and idles the back end.
module binary_fraction_to_decimal import bfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SRC_W-1:0]      source_bits_i,
  input  logic [TOP_W-1:0]      top_index_i,
  input  logic [COUNT_IN_W-1:0] digit_count_i,
  input  logic                  fill_bit_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic                  last_o
);

  bfd_qstat_t qstat;
  bfd_item_t  push_item;
  bfd_item_t  head_item;
  logic       push;
  logic       pop;

  bfd_front u_front (
    .source_bits_i (source_bits_i),
    .top_index_i   (top_index_i),
    .digit_count_i (digit_count_i),
    .fill_bit_i    (fill_bit_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  bfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  bfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (head_item),
    .pop_o       (pop),
    .digit_o     (digit_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // A delivered digit is always a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_o <= DIGIT_W'(9)))
    else $error("digit out of decimal range");

  // The queue can never report full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue status inconsistent");

  // The back end only pops a word that is present in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A queued word with a nonzero count never reaches the output in the
  // following cycle: at least the load and one halving pass stand between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !out_valid_o) |=> !out_valid_o)
    else $error("digit emitted without halving");

endmodule
